@@ rtl/core/pva_pkg.sv @@
// Package for the voice allocator: command and action codes, parameter
// defaults and the control/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package pva_pkg;

    localparam int VOICES_DEF   = 8;
    localparam int AGE_BITS_DEF = 16;

    localparam int MASK_BITS    = 8;   // width of finished_mask
    localparam int VIDX_BITS    = 3;   // width of voice_index
    localparam int NOTE_BITS    = 7;
    localparam int CMD_BITS     = 2;
    localparam int ACT_BITS     = 2;

    // input command codes
    localparam logic [CMD_BITS-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_TICK     = 2'd2;

    // result action codes
    localparam logic [ACT_BITS-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_STEAL   = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_RELEASE = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request fields, restart scan
        logic scan;     // one voice per cycle
        logic commit;   // update voice state, load result register
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;  // note on / note off
        logic hit;         // current voice matches
        logic last;        // current voice is the highest one
    } t_stat;

endpackage

@@ rtl/core/pva_ctrl.sv @@
// Controller FSM for the voice allocator: sequences accept, voice scan and
// commit, and owns both handshakes. Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  pva_pkg::t_stat i_stat,
    output pva_pkg::t_ctl  o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_mvalid, n_mvalid;
    logic   w_commit;

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_mvalid;

    // result register free or draining this cycle
    assign w_commit = (r_state == ST_COMMIT) && (!r_mvalid || m_tready);

    assign o_ctl.load   = s_tvalid && (r_state == ST_IDLE);
    assign o_ctl.scan   = (r_state == ST_SCAN);
    assign o_ctl.commit = w_commit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_tvalid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_stat.needs_scan || i_stat.hit || i_stat.last) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_commit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_mvalid = r_mvalid;
        if (w_commit)      n_mvalid = 1'b1;
        else if (m_tready) n_mvalid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
        end
    end

endmodule

@@ rtl/core/pva_dpath.sv @@
// Datapath for the voice allocator: per-voice note/busy/age registers,
// serial voice scan with oldest tracking, result register. Depends on pva_pkg.
`timescale 1ns / 1ps

module pva_dpath #(
    parameter int VOICES   = pva_pkg::VOICES_DEF,
    parameter int AGE_BITS = pva_pkg::AGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pva_pkg::t_ctl                  i_ctl,
    output pva_pkg::t_stat                 o_stat,
    input  logic [pva_pkg::CMD_BITS-1:0]   i_cmd,
    input  logic [pva_pkg::NOTE_BITS-1:0]  i_note,
    input  logic [pva_pkg::MASK_BITS-1:0]  i_mask,
    output logic [pva_pkg::ACT_BITS-1:0]   o_action,
    output logic [pva_pkg::VIDX_BITS-1:0]  o_voice_index,
    output logic [pva_pkg::NOTE_BITS-1:0]  o_voice_note
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    // voice state
    logic [pva_pkg::NOTE_BITS-1:0] r_held [VOICES];
    logic [VOICES-1:0]             r_busy;
    logic [AGE_BITS-1:0]           r_age  [VOICES];

    // captured request
    logic [pva_pkg::CMD_BITS-1:0]  r_cmd;
    logic [pva_pkg::NOTE_BITS-1:0] r_note;
    logic [pva_pkg::MASK_BITS-1:0] r_mask;

    // scan state
    logic [IDX_W-1:0]              r_idx;
    logic                          r_found;
    logic [IDX_W-1:0]              r_sel;
    logic [IDX_W-1:0]              r_old_idx;
    logic [AGE_BITS-1:0]           r_old_age;

    // result register
    logic [pva_pkg::ACT_BITS-1:0]  r_action;
    logic [pva_pkg::VIDX_BITS-1:0] r_vidx;
    logic [pva_pkg::NOTE_BITS-1:0] r_vnote;

    logic [VOICES-1:0]             w_fin;
    logic                          w_match;
    logic                          w_hit;
    logic                          w_last;
    logic [IDX_W-1:0]              w_pick;
    logic [31:0]                   w_pick_ext;

    // only the low mask bits map onto voices
    for (genvar g = 0; g < VOICES; g++) begin : g_fin
        if (g < pva_pkg::MASK_BITS) begin : g_bit
            assign w_fin[g] = r_mask[g];
        end else begin : g_none
            assign w_fin[g] = 1'b0;
        end
    end

    assign w_match = (r_held[r_idx] == r_note);
    assign w_last  = (r_idx == LAST_IDX);

    always_comb begin
        case (r_cmd)
            pva_pkg::CMD_NOTE_ON:  w_hit = !r_busy[r_idx] || w_match;
            pva_pkg::CMD_NOTE_OFF: w_hit = w_match;
            default:               w_hit = 1'b0;
        endcase
    end

    assign o_stat.needs_scan = (r_cmd == pva_pkg::CMD_NOTE_ON) ||
                               (r_cmd == pva_pkg::CMD_NOTE_OFF);
    assign o_stat.hit        = w_hit;
    assign o_stat.last       = w_last;

    assign w_pick     = r_found ? r_sel : r_old_idx;
    assign w_pick_ext = 32'(w_pick);

    // request capture and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_note    <= i_note;
            r_mask    <= i_mask;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_sel     <= '0;
            r_old_idx <= '0;
            r_old_age <= '0;
        end else if (i_ctl.scan && o_stat.needs_scan) begin
            if (w_hit) begin
                r_found <= 1'b1;
                r_sel   <= r_idx;
            end else begin
                // strict compare keeps the lowest index on ties
                if (r_age[r_idx] > r_old_age) begin
                    r_old_age <= r_age[r_idx];
                    r_old_idx <= r_idx;
                end
                if (!w_last) r_idx <= r_idx + 1'b1;
            end
        end
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_held[v] <= '0;
                r_age[v]  <= '0;
            end
        end else if (i_ctl.commit) begin
            case (r_cmd)
                pva_pkg::CMD_NOTE_ON: begin
                    r_held[w_pick] <= r_note;
                    r_busy[w_pick] <= 1'b1;
                    if (!r_found) r_age[w_pick] <= '0;
                end
                pva_pkg::CMD_TICK: begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (r_busy[v]) begin
                            if (r_age[v] != '1) r_age[v] <= r_age[v] + 1'b1;
                        end else begin
                            r_age[v] <= '0;
                        end
                        if (w_fin[v]) r_busy[v] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_action <= pva_pkg::ACT_NONE;
            r_vidx   <= '0;
            r_vnote  <= '0;
            case (r_cmd)
                pva_pkg::CMD_NOTE_ON: begin
                    r_action <= r_found ? pva_pkg::ACT_START : pva_pkg::ACT_STEAL;
                    r_vidx   <= w_pick_ext[pva_pkg::VIDX_BITS-1:0];
                    r_vnote  <= r_note;
                end
                pva_pkg::CMD_NOTE_OFF: begin
                    if (r_found) begin
                        r_action <= pva_pkg::ACT_RELEASE;
                        r_vidx   <= w_pick_ext[pva_pkg::VIDX_BITS-1:0];
                        r_vnote  <= r_note;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_action      = r_action;
    assign o_voice_index = r_vidx;
    assign o_voice_note  = r_vnote;

endmodule

@@ rtl/core/poly_voice_allocator.sv @@
// Polyphonic voice allocator, oldest-voice stealing. Top level over pva_ctrl/pva_dpath.
// Throughput: one request at a time; the serial voice scan compares one voice
//   per cycle.
// Reset (i_rst_n, synchronous, active low): all voices idle, notes and ages zero,
//   no result pending.
`timescale 1ns / 1ps

module poly_voice_allocator #(
    parameter int VOICES   = pva_pkg::VOICES_DEF,
    parameter int AGE_BITS = pva_pkg::AGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] note_number, [14:7] finished_mask, [15] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] voice_index, [9:3] voice_note, [15:10] zero
    output logic [1:0]  m_tuser    // [1:0] action
);

    pva_pkg::t_ctl  w_ctl;
    pva_pkg::t_stat w_stat;

    logic [pva_pkg::ACT_BITS-1:0]  w_action;
    logic [pva_pkg::VIDX_BITS-1:0] w_vidx;
    logic [pva_pkg::NOTE_BITS-1:0] w_vnote;

    // FSM: idle -> scan (one voice per cycle, early exit on hit) -> commit
    pva_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .i_stat   (w_stat),
        .o_ctl    (w_ctl)
    );

    // voice table, scan pointer, oldest tracker, result register
    pva_dpath #(
        .VOICES   (VOICES),
        .AGE_BITS (AGE_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .i_cmd         (s_tuser),
        .i_note        (s_tdata[6:0]),
        .i_mask        (s_tdata[14:7]),
        .o_action      (w_action),
        .o_voice_index (w_vidx),
        .o_voice_note  (w_vnote)
    );

    assign m_tuser = w_action;
    assign m_tdata = {6'b0, w_vnote, w_vidx};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // action none always carries zero index and note
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == pva_pkg::ACT_NONE)) |-> (m_tdata == 16'd0))
        else $error("action none with nonzero payload");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // a new result appears only from a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(w_ctl.commit))
        else $error("result valid without commit");

    // commit never overwrites a result the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |-> (!m_tvalid || m_tready))
        else $error("result overwritten");

endmodule

@@ tb/pva_checker.sv @@
// Checker for poly_voice_allocator: watches the request and result streams,
// predicts each result from its own copy of the voice state and compares.
// Depends on pva_pkg for command/action codes and default sizes.
`timescale 1ns / 1ps

module pva_checker #(
    parameter int VOICES   = pva_pkg::VOICES_DEF,
    parameter int AGE_BITS = pva_pkg::AGE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,   // [6:0] note_number, [14:7] finished_mask, [15] zero
    input  logic [1:0]  i_req_user,   // [1:0] cmd
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,   // [2:0] voice_index, [9:3] voice_note, [15:10] zero
    input  logic [1:0]  i_res_user,   // [1:0] action
    output int          o_errors,
    output int          o_pending
);
    import pva_pkg::*;

    typedef struct packed {
        logic [ACT_BITS-1:0]  act;
        logic [VIDX_BITS-1:0] vidx;
        logic [NOTE_BITS-1:0] note;
    } t_voice_evt;

    // shadow of the allocator state
    logic [NOTE_BITS-1:0] held_note [VOICES];
    logic                 voice_on  [VOICES];
    logic [AGE_BITS-1:0]  voice_age [VOICES];

    t_voice_evt voice_evt_q [$];
    int         err_cnt = 0;

    // Applies one request to the shadow state and returns the expected result.
    function automatic t_voice_evt alloc_step(input logic [CMD_BITS-1:0] cmd,
                                              input logic [NOTE_BITS-1:0] nt,
                                              input logic [MASK_BITS-1:0] mask);
        t_voice_evt r;
        int         oldest;
        bit         found;
        r = '0;
        found = 1'b0;
        case (cmd)
            CMD_NOTE_ON: begin
                // first idle voice or one already on this note
                for (int v = 0; v < VOICES; v++) begin
                    if (!found && (!voice_on[v] || held_note[v] == nt)) begin
                        held_note[v] = nt;
                        voice_on[v]  = 1'b1;
                        r = '{ACT_START, VIDX_BITS'(v), nt};
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    // steal the oldest, lowest index wins a tie
                    oldest = 0;
                    for (int v = 1; v < VOICES; v++)
                        if (voice_age[v] > voice_age[oldest]) oldest = v;
                    held_note[oldest] = nt;
                    voice_on[oldest]  = 1'b1;
                    voice_age[oldest] = '0;
                    r = '{ACT_STEAL, VIDX_BITS'(oldest), nt};
                end
            end
            CMD_NOTE_OFF: begin
                // match on stored note only, busy flag untouched
                for (int v = 0; v < VOICES; v++) begin
                    if (!found && held_note[v] == nt) begin
                        r = '{ACT_RELEASE, VIDX_BITS'(v), nt};
                        found = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                for (int v = 0; v < VOICES; v++) begin
                    if (voice_on[v]) begin
                        if (voice_age[v] != '1) voice_age[v] = voice_age[v] + 1'b1;
                    end else begin
                        voice_age[v] = '0;
                    end
                    // aged first, then retired by the envelope report
                    if (v < MASK_BITS && mask[v % MASK_BITS]) voice_on[v] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_voice_evt got;
        t_voice_evt want;
        bit         bad;
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                held_note[v] = '0;
                voice_on[v]  = 1'b0;
                voice_age[v] = '0;
            end
            voice_evt_q.delete();
        end else begin
            // results are checked before this edge's request is predicted
            if (i_res_valid && i_res_ready) begin
                got = '{i_res_user, i_res_data[2:0], i_res_data[9:3]};
                if (voice_evt_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%t: result with no request pending: %s%0d %s%0d %s%0d",
                                 $realtime, "act=", got.act, "idx=", got.vidx,
                                 "note=", got.note);
                end else begin
                    want = voice_evt_q.pop_front();
                    bad = (got.act != want.act) || (got.vidx != want.vidx)
                          || (got.note != want.note) || (i_res_data[15:10] != '0);
                    if (bad) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%t: mismatch exp act=%0d idx=%0d note=%0d,",
                                      " got act=%0d idx=%0d note=%0d pad=%0h"},
                                     $realtime, want.act, want.vidx, want.note,
                                     got.act, got.vidx, got.note, i_res_data[15:10]);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                voice_evt_q.push_back(alloc_step(i_req_user, i_req_data[6:0],
                                                 i_req_data[14:7]));
        end
        o_errors  <= err_cnt;
        o_pending <= voice_evt_q.size();
    end

endmodule

@@ tb/tb_poly_voice_allocator.sv @@
// Testbench top for poly_voice_allocator: drives note on/off, tick and
// unused requests with bursty timing, stalls the result side, gives the verdict.
// Depends on pva_pkg, poly_voice_allocator and pva_checker.
`timescale 1ns / 1ps

module tb_poly_voice_allocator;
    import pva_pkg::*;

    // cmd 3 has no name in the package; the block must ignore it
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    localparam int RAND_ITEMS   = 1800;
    localparam int SPREAD_TICKS = 6;       // ticks after voice 0 restarts
    localparam int IDLE_LIMIT   = 5000;    // cycles with no handshake on either side
    localparam int HOLD_AT      = 1000;    // results seen before the long hold
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;      // extra cycles after the last result is taken

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [6:0] note_number, [14:7] finished_mask, [15] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [2:0] voice_index, [9:3] voice_note, [15:10] zero
    logic [1:0]  m_tuser;         // [1:0] action

    int errors;
    int pending;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    poly_voice_allocator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pva_checker i_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_data  (s_tdata),
        .i_req_user  (s_tuser),
        .i_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .i_res_data  (m_tdata),
        .i_res_user  (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // ------------------------------------------------------------------
    // Result side: ready pattern switches mode at random (always
    // ready, coin flip, mostly stalled). Once, after HOLD_AT results, ready
    // is held low for HOLD_CYCLES while the sender keeps offering, so the
    // block backs up and drops s_tready.
    // ------------------------------------------------------------------
    int       results_seen = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;
    int       rx_cycle     = 0;
    int       rx_mode      = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) results_seen <= results_seen + 1;
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 63) rx_mode <= $urandom_range(0, 2);
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake means the block hung or a
    // result never came.
    // ------------------------------------------------------------------
    int idle_cyc = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side. Requests go out in bursts of 1..12 with idle gaps
    // between bursts; gapless turns the gaps off.
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit gapless    = 1'b0;

    task automatic send_req(input logic [CMD_BITS-1:0] cmd, input logic [NOTE_BITS-1:0] nt,
                            input logic [MASK_BITS-1:0] mask);
        int gap;
        if (burst_left == 0) begin
            if (!gapless) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, mask, nt};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // notes recently started, so note offs mostly hit something
    logic [NOTE_BITS-1:0] recent_notes [16];
    int                   recent_wr = 0;
    int                   pool_base = 0;

    initial begin
        logic [CMD_BITS-1:0]  cmd;
        logic [NOTE_BITS-1:0] nt;
        logic [MASK_BITS-1:0] mask;
        int                   sel;

        for (int i = 0; i < 16; i++) recent_notes[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // note off right after reset matches idle voice 0 holding note 0
        send_req(CMD_NOTE_OFF, 7'd0,   8'h00);
        send_req(CMD_NOTE_OFF, 7'd127, 8'hFF);   // nobody holds it: none
        send_req(CMD_UNUSED,   7'd127, 8'hFF);   // ignored
        send_req(CMD_TICK,     7'd127, 8'h00);
        send_req(CMD_NOTE_ON,  7'd0,   8'hFF);   // voice 0
        send_req(CMD_NOTE_ON,  7'd127, 8'h00);   // voice 1
        send_req(CMD_NOTE_ON,  7'd127, 8'h00);   // same note reuses voice 1, age kept
        send_req(CMD_NOTE_ON,  7'h55,  8'h00);
        send_req(CMD_NOTE_ON,  7'h2A,  8'h00);
        send_req(CMD_NOTE_ON,  7'd1,   8'h00);
        send_req(CMD_NOTE_ON,  7'd64,  8'h00);
        send_req(CMD_NOTE_ON,  7'd100, 8'h00);
        send_req(CMD_NOTE_ON,  7'd3,   8'h00);   // all eight busy now
        send_req(CMD_TICK,     7'd0,   8'h00);
        send_req(CMD_NOTE_ON,  7'd77,  8'h00);   // steal, all ages equal: voice 0
        send_req(CMD_TICK,     7'd0,   8'h00);
        send_req(CMD_NOTE_ON,  7'd78,  8'h00);   // steal, tie among 1..7: voice 1
        send_req(CMD_TICK,     7'd0,   8'hAA);   // odd voices aged then retired
        send_req(CMD_NOTE_ON,  7'd90,  8'h00);   // first idle: voice 1
        send_req(CMD_NOTE_OFF, 7'h55,  8'h00);
        send_req(CMD_TICK,     7'd0,   8'hFF);   // everyone idle
        send_req(CMD_TICK,     7'd0,   8'h55);
        send_req(CMD_NOTE_OFF, 7'd3,   8'h00);   // idle voice still matches

        // ---- staggered ages: voice 0 restarted 10 ticks after the rest,
        // so the next steal passes it over and takes voice 1
        gapless = 1'b1;
        for (int v = 0; v < VOICES_DEF; v++) send_req(CMD_NOTE_ON, 7'(20 + v), 8'h00);
        repeat (10) send_req(CMD_TICK, 7'd0, 8'h00);
        send_req(CMD_NOTE_ON, 7'd30, 8'h00);
        for (int n = 0; n < SPREAD_TICKS; n++) send_req(CMD_TICK, 7'($urandom), 8'h00);
        send_req(CMD_NOTE_ON, 7'd31, 8'h00);
        send_req(CMD_TICK, 7'd0, 8'hFF);
        gapless = 1'b0;

        // ---- random ----
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 200 == 0) pool_base = $urandom_range(0, 116);
            gapless = (n >= 600 && n < 800);
            sel  = $urandom_range(0, 99);
            nt   = 7'($urandom);
            mask = 8'($urandom);
            if (sel < 40) begin
                cmd = CMD_NOTE_ON;
                // narrow pool gives repeated notes and voice reuse
                if ($urandom_range(0, 9) < 6) nt = 7'(pool_base + $urandom_range(0, 11));
                recent_notes[recent_wr] = nt;
                recent_wr = (recent_wr + 1) % 16;
            end else if (sel < 60) begin
                cmd = CMD_NOTE_OFF;
                if ($urandom_range(0, 9) < 7) nt = recent_notes[$urandom_range(0, 15)];
            end else if (sel < 95) begin
                cmd = CMD_TICK;
                // keep retirements sparse so voices fill up and get stolen
                sel = $urandom_range(0, 9);
                if (sel < 6) mask = '0;
                else if (sel < 9) mask = 8'(1 << $urandom_range(0, 7));
            end else begin
                cmd = CMD_UNUSED;
            end
            send_req(cmd, nt, mask);
        end

        // ---- drain ----
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pva_pkg.sv
rtl/core/pva_ctrl.sv
rtl/core/pva_dpath.sv
rtl/core/poly_voice_allocator.sv
tb/pva_checker.sv
tb/tb_poly_voice_allocator.sv
